@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define BPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bpc_pkg.sv @@
// Package: constants and codes of the barometric pressure compensation block.
package bpc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_CAL_A = 2'd0;
    localparam logic [1:0] CFG_CAL_B = 2'd1;
    localparam logic [1:0] CFG_CAL_C = 2'd2;
    localparam logic [1:0] CFG_OSS   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_TDIV = 2'd1;
    localparam logic [1:0] ST_PDIV = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    // Reset value of the oversampling mode
    localparam logic [1:0] OSS_RESET = 2'd3;

    // Datasheet constants
    localparam logic signed [28:0] C_B6_OFFSET = 29'sd4000;
    localparam logic [31:0]        C_B4_OFFSET = 32'd32768;
    localparam logic [15:0]        C_B7_SCALE  = 16'd50000;
    localparam logic signed [15:0] C_P_X1      = 16'sd3038;
    localparam logic signed [15:0] C_P_X2      = -16'sd7357;
    localparam logic signed [17:0] C_P_OFFSET  = 18'sd3791;

    // Saturation limits
    localparam logic signed [24:0] TEMP_MAX  = 25'sd32767;
    localparam logic signed [24:0] TEMP_MIN  = -25'sd32768;
    localparam logic signed [31:0] PRESS_MAX = 32'sd262143;

endpackage

@@ hdl/barometric_pressure_compensation.sv @@
// Top level: pipelined barometric temperature and pressure compensation.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_raw_temperature, i_raw_pressure_word
//  out     | output    | o_out_valid / i_out_ready  | o_temperature_tenths, o_pressure_pa,
//          |           |                            | o_status
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One item enters per cycle while the output is taken; the two bit-per-stage dividers
// (27 stages for temperature, 32 for pressure) and 15 arithmetic stages form the pipeline.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// The whole pipeline advances together; when the output item is not taken, every
// stage holds and o_in_ready drops.
module barometric_pressure_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_raw_temperature,
    input  logic [23:0]        i_raw_pressure_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_temperature_tenths,
    output logic [17:0]        o_pressure_pa,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= bpc_pkg::OSS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpc_pkg::CFG_CAL_A: r_cal_a <= i_cfg_data;
                bpc_pkg::CFG_CAL_B: r_cal_b <= i_cfg_data;
                bpc_pkg::CFG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                bpc_pkg::CFG_OSS:   r_oss   <= i_cfg_data[1:0];
                default:            r_oss   <= r_oss;
            endcase
        end
    end

    // calibration fields
    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = $signed(r_cal_a[63:48]);
    assign ac2 = $signed(r_cal_a[47:32]);
    assign ac3 = $signed(r_cal_a[31:16]);
    assign ac4 = r_cal_a[15:0];
    assign ac5 = r_cal_b[63:48];
    assign ac6 = r_cal_b[47:32];
    assign b1  = $signed(r_cal_b[31:16]);
    assign b2  = $signed(r_cal_b[15:0]);
    assign mc  = $signed(r_cal_c[31:16]);
    assign md  = $signed(r_cal_c[15:0]);

    // ---------------- pipeline control ----------------
    logic r_ov;
    logic w_adv;

    assign w_adv      = !r_ov || i_out_ready;
    assign o_in_ready = w_adv;

    // ---------------- S1: UT - AC6 ----------------
    logic               r1_v;
    logic signed [16:0] r1_d;
    logic [23:0]        r1_up;
    logic signed [16:0] w1_d;

    assign w1_d = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, ac6});

    // ---------------- S2: times AC5 ----------------
    logic               r2_v;
    logic signed [33:0] r2_prod;
    logic [23:0]        r2_up;

    // ---------------- S3: X1, divisor and dividend magnitudes ----------------
    logic               r3_v;
    logic [26:0]        r3_num;
    logic [17:0]        r3_den;
    logic [44:0]        r3_side;
    logic signed [18:0] w3_x1;
    logic signed [19:0] w3_den;
    logic [19:0]        w3_den_neg;
    logic [15:0]        w3_mc_mag;

    assign w3_x1      = r2_prod[33:15];
    assign w3_den     = 20'(w3_x1) + 20'(md);
    assign w3_den_neg = ~w3_den + 20'd1;
    assign w3_mc_mag  = mc[15] ? (~mc + 16'd1) : mc;

    // ---------------- divider 1: MC*2048 / (X1 + MD) ----------------
    logic        w_d1_v;
    logic [26:0] w_d1_q;
    logic [44:0] w_d1_side;

    bpc_div #(.DW(27), .VW(18), .SW(45)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r3_v),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_vld   (w_d1_v),
        .o_quo   (w_d1_q),
        .o_side  (w_d1_side)
    );

    // ---------------- S4: B5 ----------------
    logic               r4_v;
    logic signed [27:0] r4_b5;
    logic [23:0]        r4_up;
    logic               r4_tz;
    logic signed [18:0] w4_x1;
    logic [23:0]        w4_up;
    logic               w4_neg;
    logic               w4_tz;
    logic signed [27:0] w4_x2;

    assign {w4_x1, w4_up, w4_neg, w4_tz} = w_d1_side;
    assign w4_x2 = w4_neg ? -$signed({1'b0, w_d1_q}) : $signed({1'b0, w_d1_q});

    // ---------------- S5: temperature and B6 ----------------
    logic               r5_v;
    logic signed [15:0] r5_temp;
    logic               r5_tsat;
    logic signed [28:0] r5_b6;
    logic [23:0]        r5_up;
    logic               r5_tz;
    logic signed [28:0] w5_sum;
    logic signed [24:0] w5_tp;

    assign w5_sum = 29'(r4_b5) + 29'sd8;
    assign w5_tp  = w5_sum[28:4];

    // ---------------- S6: B6 products ----------------
    logic               r6_v;
    logic signed [31:0] r6_sq, r6_a2, r6_a3;
    logic signed [15:0] r6_temp;
    logic               r6_tsat;
    logic [23:0]        r6_up;
    logic               r6_tz;
    logic signed [57:0] w6_sq;
    logic signed [44:0] w6_a2, w6_a3;

    assign w6_sq = r5_b6 * r5_b6;
    assign w6_a2 = ac2 * r5_b6;
    assign w6_a3 = ac3 * r5_b6;

    // ---------------- S7: products with T ----------------
    logic               r7_v;
    logic signed [31:0] r7_bt2, r7_bt1;
    logic signed [20:0] r7_a2s;
    logic signed [18:0] r7_a3s;
    logic signed [15:0] r7_temp;
    logic               r7_tsat;
    logic [23:0]        r7_up;
    logic               r7_tz;
    logic signed [19:0] w7_t;
    logic signed [35:0] w7_bt2, w7_bt1;

    assign w7_t   = r6_sq[31:12];
    assign w7_bt2 = b2 * w7_t;
    assign w7_bt1 = b1 * w7_t;

    // ---------------- S8: B3 before scaling, X3 for B4 ----------------
    logic               r8_v;
    logic signed [22:0] r8_b3a;
    logic signed [17:0] r8_x3p;
    logic signed [15:0] r8_temp;
    logic               r8_tsat;
    logic [23:0]        r8_up;
    logic               r8_tz;
    logic signed [21:0] w8_x3;
    logic signed [19:0] w8_sp;

    assign w8_x3 = 22'($signed(r7_bt2[31:11])) + 22'(r7_a2s);
    assign w8_sp = 20'(r7_a3s) + 20'($signed(r7_bt1[31:16])) + 20'sd2;

    // ---------------- S9: B3 and the B4 product ----------------
    logic               r9_v;
    logic signed [24:0] r9_b3;
    logic [31:0]        r9_b4p;
    logic signed [15:0] r9_temp;
    logic               r9_tsat;
    logic [23:0]        r9_up;
    logic               r9_tz;
    logic signed [26:0] w9_b3s, w9_v, w9_adj;
    logic [31:0]        w9_x3u;
    logic [47:0]        w9_b4full;

    assign w9_b3s    = 27'(r8_b3a) <<< r_oss;
    assign w9_v      = w9_b3s + 27'sd2;
    // divide by four toward zero
    assign w9_adj    = w9_v[26] ? (w9_v + 27'sd3) : w9_v;
    assign w9_x3u    = 32'(r8_x3p) + bpc_pkg::C_B4_OFFSET;
    assign w9_b4full = ac4 * w9_x3u;

    // ---------------- S10: B4 and UP - B3 ----------------
    logic               r10_v;
    logic [16:0]        r10_b4;
    logic [31:0]        r10_diff;
    logic signed [15:0] r10_temp;
    logic               r10_tsat;
    logic               r10_tz;

    // ---------------- S11: B7 ----------------
    logic               r11_v;
    logic [31:0]        r11_b7;
    logic [16:0]        r11_b4;
    logic signed [15:0] r11_temp;
    logic               r11_tsat;
    logic               r11_tz;
    logic [15:0]        w11_k;
    logic [47:0]        w11_b7full;

    assign w11_k      = bpc_pkg::C_B7_SCALE >> r_oss;
    assign w11_b7full = r10_diff * w11_k;

    // ---------------- divider 2: B7 / B4 ----------------
    logic        w_d2_big;
    logic [31:0] w_d2_num;
    logic [19:0] w_d2_in_side;
    logic        w_d2_v;
    logic [31:0] w_d2_q;
    logic [19:0] w_d2_side;

    assign w_d2_big     = r11_b7[31];
    assign w_d2_num     = w_d2_big ? r11_b7 : {r11_b7[30:0], 1'b0};
    assign w_d2_in_side = {r11_temp, r11_tsat, r11_tz, w_d2_big, (r11_b4 == 17'd0)};

    bpc_div #(.DW(32), .VW(17), .SW(20)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r11_v),
        .i_num   (w_d2_num),
        .i_den   (r11_b4),
        .i_side  (w_d2_in_side),
        .o_vld   (w_d2_v),
        .o_quo   (w_d2_q),
        .o_side  (w_d2_side)
    );

    // ---------------- S12: P and its first products ----------------
    logic               r12_v;
    logic signed [31:0] r12_p, r12_m1, r12_m2;
    logic signed [15:0] r12_temp;
    logic               r12_tsat, r12_tz, r12_b4z;
    logic signed [15:0] w12_temp;
    logic               w12_tsat, w12_tz, w12_big, w12_b4z;
    logic signed [31:0] w12_p;
    logic signed [23:0] w12_x1;
    logic signed [47:0] w12_m1, w12_m2;

    assign {w12_temp, w12_tsat, w12_tz, w12_big, w12_b4z} = w_d2_side;
    assign w12_p  = w12_big ? $signed({w_d2_q[30:0], 1'b0}) : $signed(w_d2_q);
    assign w12_x1 = w12_p[31:8];
    assign w12_m1 = w12_x1 * w12_x1;
    assign w12_m2 = w12_p * bpc_pkg::C_P_X2;

    // ---------------- S13: X1 * 3038 ----------------
    logic               r13_v;
    logic signed [31:0] r13_p, r13_m3;
    logic signed [15:0] r13_x2;
    logic signed [15:0] r13_temp;
    logic               r13_tsat, r13_tz, r13_b4z;
    logic signed [47:0] w13_m3;

    assign w13_m3 = r12_m1 * bpc_pkg::C_P_X1;

    // ---------------- S14: final pressure ----------------
    logic               r14_v;
    logic signed [31:0] r14_p;
    logic signed [15:0] r14_temp;
    logic               r14_tsat, r14_tz, r14_b4z;
    logic signed [17:0] w14_s;

    assign w14_s = 18'($signed(r13_m3[31:16])) + 18'(r13_x2) + bpc_pkg::C_P_OFFSET;

    // ---------------- output stage: saturation and status ----------------
    logic signed [15:0] n_temp;
    logic [17:0]        n_press;
    logic [1:0]         n_status;
    logic               w_psat;

    assign w_psat = (r14_p < 32'sd0) || (r14_p > bpc_pkg::PRESS_MAX);

    always_comb begin
        n_temp   = r14_temp;
        n_press  = '0;
        n_status = bpc_pkg::ST_OK;
        if (r14_tz) begin
            n_temp   = '0;
            n_status = bpc_pkg::ST_TDIV;
        end else if (r14_b4z) begin
            n_status = bpc_pkg::ST_PDIV;
        end else begin
            if (r14_p < 32'sd0) begin
                n_press = '0;
            end else if (r14_p > bpc_pkg::PRESS_MAX) begin
                n_press = '1;
            end else begin
                n_press = r14_p[17:0];
            end
            if (r14_tsat || w_psat) begin
                n_status = bpc_pkg::ST_SAT;
            end
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
            r13_v <= 1'b0;
            r14_v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_adv) begin
            r1_v  <= i_in_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= w_d1_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
            r12_v <= w_d2_v;
            r13_v <= r12_v;
            r14_v <= r13_v;
            r_ov  <= r14_v;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // S1..S3
            r1_d    <= w1_d;
            r1_up   <= i_raw_pressure_word;
            r2_prod <= r1_d * $signed({1'b0, ac5});
            r2_up   <= r1_up;
            r3_num  <= {w3_mc_mag, 11'd0};
            r3_den  <= w3_den[19] ? w3_den_neg[17:0] : w3_den[17:0];
            r3_side <= {w3_x1, r2_up, (mc[15] ^ w3_den[19]), (w3_den == 20'sd0)};
            // S4
            r4_b5   <= 28'(w4_x1) + w4_x2;
            r4_up   <= w4_up;
            r4_tz   <= w4_tz;
            // S5
            if (w5_tp > bpc_pkg::TEMP_MAX) begin
                r5_temp <= 16'sd32767;
                r5_tsat <= 1'b1;
            end else if (w5_tp < bpc_pkg::TEMP_MIN) begin
                r5_temp <= -16'sd32768;
                r5_tsat <= 1'b1;
            end else begin
                r5_temp <= w5_tp[15:0];
                r5_tsat <= 1'b0;
            end
            r5_b6   <= 29'(r4_b5) - bpc_pkg::C_B6_OFFSET;
            r5_up   <= r4_up;
            r5_tz   <= r4_tz;
            // S6
            r6_sq   <= w6_sq[31:0];
            r6_a2   <= w6_a2[31:0];
            r6_a3   <= w6_a3[31:0];
            r6_temp <= r5_temp;
            r6_tsat <= r5_tsat;
            r6_up   <= r5_up;
            r6_tz   <= r5_tz;
            // S7
            r7_bt2  <= w7_bt2[31:0];
            r7_bt1  <= w7_bt1[31:0];
            r7_a2s  <= r6_a2[31:11];
            r7_a3s  <= r6_a3[31:13];
            r7_temp <= r6_temp;
            r7_tsat <= r6_tsat;
            r7_up   <= r6_up;
            r7_tz   <= r6_tz;
            // S8
            r8_b3a  <= 23'($signed({ac1, 2'b00})) + 23'(w8_x3);
            r8_x3p  <= w8_sp[19:2];
            r8_temp <= r7_temp;
            r8_tsat <= r7_tsat;
            r8_up   <= r7_up;
            r8_tz   <= r7_tz;
            // S9
            r9_b3   <= w9_adj[26:2];
            r9_b4p  <= w9_b4full[31:0];
            r9_temp <= r8_temp;
            r9_tsat <= r8_tsat;
            r9_up   <= r8_up;
            r9_tz   <= r8_tz;
            // S10
            r10_b4   <= r9_b4p[31:15];
            r10_diff <= {8'd0, r9_up} - 32'(r9_b3);
            r10_temp <= r9_temp;
            r10_tsat <= r9_tsat;
            r10_tz   <= r9_tz;
            // S11
            r11_b7   <= w11_b7full[31:0];
            r11_b4   <= r10_b4;
            r11_temp <= r10_temp;
            r11_tsat <= r10_tsat;
            r11_tz   <= r10_tz;
            // S12
            r12_p    <= w12_p;
            r12_m1   <= w12_m1[31:0];
            r12_m2   <= w12_m2[31:0];
            r12_temp <= w12_temp;
            r12_tsat <= w12_tsat;
            r12_tz   <= w12_tz;
            r12_b4z  <= w12_b4z;
            // S13
            r13_p    <= r12_p;
            r13_m3   <= w13_m3[31:0];
            r13_x2   <= r12_m2[31:16];
            r13_temp <= r12_temp;
            r13_tsat <= r12_tsat;
            r13_tz   <= r12_tz;
            r13_b4z  <= r12_b4z;
            // S14
            r14_p    <= r13_p + 32'($signed(w14_s[17:4]));
            r14_temp <= r13_temp;
            r14_tsat <= r13_tsat;
            r14_tz   <= r13_tz;
            r14_b4z  <= r13_b4z;
            // output register
            o_temperature_tenths <= n_temp;
            o_pressure_pa        <= n_press;
            o_status             <= n_status;
        end
    end

    assign o_out_valid = r_ov;

endmodule

@@ hdl/bpc_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
module bpc_div #(
    parameter int DW = 32,
    parameter int VW = 17,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [DW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [VW-1:0] r_rem  [DW];
    logic [DW-1:0] r_quo  [DW];
    logic [DW-1:0] r_num  [DW];
    logic [VW-1:0] r_den  [DW];
    logic [SW-1:0] r_side [DW];
    logic          r_vld  [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [VW-1:0] w_rem;
        logic [DW-1:0] w_quo;
        logic [DW-1:0] w_num;
        logic [VW-1:0] w_den;
        logic [SW-1:0] w_side;
        logic          w_vld;
        logic [VW:0]   w_trial;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_quo  = '0;
            assign w_num  = i_num;
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_num  = r_num[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        // bring down the next dividend bit and try the subtraction
        assign w_trial = {w_rem, w_num[DW-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? VW'(w_trial - {1'b0, w_den}) : w_trial[VW-1:0];
                r_quo[k]  <= {w_quo[DW-2:0], w_ge};
                r_num[k]  <= {w_num[DW-2:0], 1'b0};
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[DW-1];
    assign o_quo  = r_quo[DW-1];
    assign o_side = r_side[DW-1];

endmodule

@@ hdl/bpc_chk.sv @@
// Port-level checker for the compensation block, bound to the top level.
`include "assert_macros.svh"

module bpc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [15:0]        i_raw_temperature,
    input logic [23:0]        i_raw_pressure_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_temperature_tenths,
    input logic [17:0]        o_pressure_pa,
    input logic [1:0]         o_status,
    input logic               i_cfg_we,
    input logic [1:0]         i_cfg_idx,
    input logic [63:0]        i_cfg_data
);

    // zero temperature divisor clears both results
    `BPC_ASSERT_IMPLY(a_tdiv_zero, i_clk, i_rst_n, o_out_valid && (o_status == bpc_pkg::ST_TDIV), (o_temperature_tenths == 16'sd0) && (o_pressure_pa == 18'd0), "temperature divisor zero without cleared results")

    // zero pressure divisor clears the pressure
    `BPC_ASSERT_IMPLY(a_pdiv_zero, i_clk, i_rst_n, o_out_valid && (o_status == bpc_pkg::ST_PDIV), o_pressure_pa == 18'd0, "pressure divisor zero with non-zero pressure")

    // a waiting result holds the whole pipeline
    `BPC_ASSERT_IMPLY(a_stall_blocks, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready, "input taken while output stalled")

    // a stalled result stays put
    `BPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_pressure_pa) && $stable(o_temperature_tenths), "stalled result changed")

endmodule

bind barometric_pressure_compensation bpc_chk u_bpc_chk (.*);

@@ bench/tb.sv @@
// Testbench for the barometric pressure compensation block: queue-fed driver and checker.
`timescale 1ns / 100ps

module tb;

    // Raw sensor sample and compensated reading
    typedef struct packed {
        logic [15:0] ut;
        logic [23:0] up;
    } t_raw_sample;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [17:0]        press;
        logic [1:0]         status;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [15:0]        i_raw_temperature = '0;
    logic [23:0]        i_raw_pressure_word = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_temperature_tenths;
    logic [17:0]        o_pressure_pa;
    logic [1:0]         o_status;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [63:0]        i_cfg_data = '0;

    // Local copy of the calibration registers
    logic [63:0] cal_a = '0;
    logic [63:0] cal_b = '0;
    logic [31:0] cal_c = '0;
    logic [1:0]  oss   = bpc_pkg::OSS_RESET;

    t_raw_sample sample_q[$];
    t_reading    pending_readings[$];
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          n_errors = 0;
    bit          taken = 1'b0;

    barometric_pressure_compensation DUT (.*);

    always #5 i_clk = ~i_clk;

    // 32-bit register wrap, read back signed
    function automatic longint w32(longint v);
        int r;
        r = v[31:0];
        return r;
    endfunction

    // Integer datasheet compensation at the block's widths
    function automatic t_reading compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
        t_reading    r;
        longint      ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        longint      ut, x1, x2, x3, b5, b6, t, b3, p, temp, prod;
        logic [31:0] b4, b7, diff, scale, pu, q;
        ac1 = longint'($signed(cal_a[63:48]));
        ac2 = longint'($signed(cal_a[47:32]));
        ac3 = longint'($signed(cal_a[31:16]));
        ac4 = longint'({48'd0, cal_a[15:0]});
        ac5 = longint'({48'd0, cal_b[63:48]});
        ac6 = longint'({48'd0, cal_b[47:32]});
        b1  = longint'($signed(cal_b[31:16]));
        b2  = longint'($signed(cal_b[15:0]));
        mc  = longint'($signed(cal_c[31:16]));
        md  = longint'($signed(cal_c[15:0]));
        ut  = longint'({48'd0, ut_raw});
        r.status = bpc_pkg::ST_OK;
        x1 = ((ut - ac6) * ac5) >>> 15;
        if (x1 + md == 0) begin
            r.temp = '0;
            r.press = '0;
            r.status = bpc_pkg::ST_TDIV;
            return r;
        end
        x2 = (mc * 2048) / (x1 + md);
        b5 = x1 + x2;
        temp = (b5 + 8) >>> 4;
        if (temp > 32767) begin
            temp = 32767;
            r.status = bpc_pkg::ST_SAT;
        end
        if (temp < -32768) begin
            temp = -32768;
            r.status = bpc_pkg::ST_SAT;
        end
        r.temp = temp[15:0];
        // B3 path
        b6 = w32(b5 - 4000);
        t  = w32(b6 * b6) >>> 12;
        x1 = w32(b2 * t) >>> 11;
        x2 = w32(ac2 * b6) >>> 11;
        x3 = w32(x1 + x2);
        b3 = w32(ac1 * 4 + x3);
        b3 = w32(b3 * (longint'(1) << oss));
        b3 = w32(b3 + 2) / 4;
        // B4 and B7
        x1 = w32(ac3 * b6) >>> 13;
        x2 = w32(b1 * t) >>> 16;
        x3 = w32(x1 + x2 + 2) >>> 2;
        prod = ac4 * (x3 + 32768);
        b4 = prod[31:0] >> 15;
        diff = {8'd0, up_raw} - b3[31:0];
        scale = 32'd50000 >> oss;
        b7 = diff * scale;
        if (b4 == 0) begin
            r.press = '0;
            r.status = bpc_pkg::ST_PDIV;
            return r;
        end
        if (b7 < 32'h8000_0000) begin
            pu = {b7[30:0], 1'b0} / b4;
        end else begin
            q = b7 / b4;
            pu = {q[30:0], 1'b0};
        end
        p  = longint'($signed(pu));
        x1 = p >>> 8;
        x1 = w32(x1 * x1);
        x1 = w32(x1 * 3038) >>> 16;
        x2 = w32(-7357 * p) >>> 16;
        p  = w32(p + (w32(x1 + x2 + 3791) >>> 4));
        if (p < 0) begin
            p = 0;
            r.status = bpc_pkg::ST_SAT;
        end
        if (p > 262143) begin
            p = 262143;
            r.status = bpc_pkg::ST_SAT;
        end
        r.press = p[17:0];
        return r;
    endfunction

    // Record accepted items and predict their readings
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_readings.push_back(compensate(i_raw_temperature, i_raw_pressure_word));
            taken = 1'b1;
        end
    end

    // Driver: next item or idle at the falling edge
    always @(negedge i_clk) begin
        t_raw_sample s;
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        if (!i_in_valid || taken) begin
            taken = 1'b0;
            if (i_rst_n && sample_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s = sample_q.pop_front();
                i_raw_temperature <= s.ut;
                i_raw_pressure_word <= s.up;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each reading with the oldest prediction
    always @(posedge i_clk) begin
        t_reading e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected reading: temp %0d press %0d status %0d",
                             o_temperature_tenths, o_pressure_pa, o_status);
            end else begin
                e = pending_readings.pop_front();
                if (e.temp !== o_temperature_tenths || e.press !== o_pressure_pa
                        || e.status !== o_status) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp temp %0d press %0d status %0d, got %0d %0d %0d",
                                 e.temp, e.press, e.status,
                                 o_temperature_tenths, o_pressure_pa, o_status);
                end
            end
        end
    end

    // Wait until the pipeline has drained
    task automatic wait_idle();
        wait (sample_q.size() == 0 && !i_in_valid && pending_readings.size() == 0);
        repeat (90) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            bpc_pkg::CFG_CAL_A: cal_a = data;
            bpc_pkg::CFG_CAL_B: cal_b = data;
            bpc_pkg::CFG_CAL_C: cal_c = data[31:0];
            default:            oss = data[1:0];
        endcase
    endtask

    task automatic push(logic [15:0] ut, logic [23:0] up);
        t_raw_sample s;
        s.ut = ut;
        s.up = up;
        sample_q.push_back(s);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Stimulus: phases of calibration settings and idling modes
    initial begin
        logic [63:0] a, b, c;
        logic [1:0]  m;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
                default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
            endcase
            // Datasheet-like calibration, slightly perturbed
            a = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
            b = {16'd32757, 16'd23153, 16'd6190, 16'd4};
            c = {32'd0, 16'hDDF9, 16'd2868};
            m = ph[1:0];
            case (ph)
                0: ; // reset values: the temperature divisor is zero
                1: m = 2'd0;
                2: c[15:0] = 16'd0;           // lets UT = ac6 zero the divisor
                3: a[15:0] = 16'd0;           // pressure divisor zero
                4: begin a = '1; b = '1; c = {32'hFFFF_FFFF, 32'hFFFF_FFFF}; end
                5: begin a = '0; b = 64'h0000_FFFF_0000_0000; c = 64'h0000_0000_8000_7FFF; end
                default: if ($urandom_range(1)) begin
                    a = rand64(); b = rand64(); c = rand64(); m = 2'($urandom());
                end else begin
                    a[63:48] = 16'(a[63:48] + $urandom_range(200) - 100);
                    b[47:32] = 16'(b[47:32] + $urandom_range(4000) - 2000);
                    c[31:16] = 16'(c[31:16] + $urandom_range(2000) - 1000);
                    c[63:32] = $urandom();
                end
            endcase
            if (ph != 0) begin
                wait_idle();
                write_reg(bpc_pkg::CFG_CAL_A, a);
                write_reg(bpc_pkg::CFG_CAL_B, b);
                write_reg(bpc_pkg::CFG_CAL_C, c);
                write_reg(bpc_pkg::CFG_OSS, {$urandom(), $urandom()} & ~64'd3 | m);
                @(negedge i_clk);
                i_cfg_we <= 1'b0;
            end
            // Directed: extremes and named special cases
            push(16'd27898, 24'd23843);
            push(16'd0, 24'd0);
            push(16'hFFFF, 24'hFF_FFFF);
            push(16'd0, 24'hFF_FFFF);
            push(16'hFFFF, 24'd0);
            push(16'd23153, 24'd23843 << m);
            push(16'h5555, 24'hAAAAAA);
            push(16'hAAAA, 24'h555555);
            // Random: mostly plausible readings, some noise
            for (int k = 0; k < 160; k++) begin
                if ($urandom_range(3) != 0)
                    push(16'($urandom_range(35000, 20000)),
                         24'($urandom_range(45000, 15000) << oss));
                else
                    push(16'($urandom()), 24'($urandom()));
            end
        end
        wait_idle();
        if (pending_readings.size() != 0)
            n_errors++;
        if (n_errors == 0) begin
            $display("[barometric_pressure_compensation] OK");
        end else begin
            $display("[barometric_pressure_compensation] ERROR");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5ms;
        $display("[barometric_pressure_compensation] ERROR");
        $finish;
    end

endmodule
